### sv/arf_pkg.sv
// Shared types and constants for the core register file.
package arf_pkg;

   // Register file geometry
   localparam int unsigned NUM_GEN_REGS = 13;
   localparam logic [3:0]  REG_SP       = 4'd13;
   localparam logic [3:0]  REG_LR       = 4'd14;
   localparam logic [3:0]  REG_PC       = 4'd15;

   // Reset values
   localparam logic [31:0] LINK_RESET   = 32'hFFFF_FFFF;

   // CSR map
   localparam logic        CSR_LINK_RESET_SEL = 1'b0;

   // Request kinds carried in req_tuser
   typedef enum logic [3:0] {
      REQ_READ_REG    = 4'd0,
      REQ_WRITE_REG   = 4'd1,
      REQ_WRITE_FLAGS = 4'd2,
      REQ_SET_NZ      = 4'd3,
      REQ_READ_XPSR   = 4'd4,
      REQ_WRITE_APSR  = 4'd5,
      REQ_WRITE_XPSR  = 4'd6,
      REQ_CONDITION   = 4'd7,
      REQ_SET_SSEL    = 4'd8
   } req_kind_type;

   // Condition groups (condition code bits 3:1)
   typedef enum logic [2:0] {
      COND_EQ = 3'd0,
      COND_CS = 3'd1,
      COND_MI = 3'd2,
      COND_VS = 3'd3,
      COND_HI = 3'd4,
      COND_GE = 3'd5,
      COND_GT = 3'd6,
      COND_AL = 3'd7
   } cond_group_type;

   localparam logic [3:0] COND_ALWAYS_ALT = 4'hF;

   // One request transaction
   typedef struct packed {
      req_kind_type kind;
      logic [3:0]   reg_index;
      logic [31:0]  write_value;
      logic [3:0]   flags_in;
      logic [3:0]   condition_code;
      logic         stack_select_in;
   } req_item_type;

   // One response transaction
   typedef struct packed {
      logic [31:0] read_data;
      logic        condition_passed;
      logic [3:0]  flags_out;
   } rsp_item_type;

endpackage

### sv/arf_csr.sv
// APB-style configuration registers of the core register file.
module arf_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [31:0] link_cfg_ff;
   logic [31:0] link_cfg_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready
                  && (csr_paddr[2] == arf_pkg::CSR_LINK_RESET_SEL);

   // Link reset value register
   always_comb begin
      link_cfg_in = link_cfg_ff;
      if (wr_en) begin
         link_cfg_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_cfg_ff <= arf_pkg::LINK_RESET;
      end else begin
         link_cfg_ff <= link_cfg_in;
      end
   end

   // Read back
   assign csr_prdata = (csr_paddr[2] == arf_pkg::CSR_LINK_RESET_SEL) ? link_cfg_ff : 32'd0;

endmodule

### sv/arf_cond_check.sv
// Condition code evaluation against the current flags.
module arf_cond_check (
   input  logic [3:0] flags,
   input  logic [3:0] code,
   output logic       passed
);

   logic fn, fz, fc, fv;
   logic base;

   assign fn = flags[3];
   assign fz = flags[2];
   assign fc = flags[1];
   assign fv = flags[0];

   // Even code of each pair
   always_comb begin
      case (arf_pkg::cond_group_type'(code[3:1]))
         arf_pkg::COND_EQ: base = fz;
         arf_pkg::COND_CS: base = fc;
         arf_pkg::COND_MI: base = fn;
         arf_pkg::COND_VS: base = fv;
         arf_pkg::COND_HI: base = fc && !fz;
         arf_pkg::COND_GE: base = (fn == fv);
         arf_pkg::COND_GT: base = (fn == fv) && !fz;
         default:          base = 1'b1;
      endcase
   end

   // Odd codes invert, except the second always code
   assign passed = (code[0] && (code != arf_pkg::COND_ALWAYS_ALT)) ? !base : base;

endmodule

### sv/arf_core_regs.sv
// Core registers, PSR state and per-request execution logic.
module arf_core_regs (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  exec,
   input  arf_pkg::req_item_type req,
   output arf_pkg::rsp_item_type rsp
);

   logic [31:0] gen_ff [arf_pkg::NUM_GEN_REGS];
   logic [31:0] gen_in [arf_pkg::NUM_GEN_REGS];
   logic [31:0] pc_ff, pc_in;
   logic [31:0] lr_ff, lr_in;
   logic [31:0] msp_ff, msp_in;
   logic [31:0] psp_ff, psp_in;
   logic [3:0]  flags_ff, flags_in;
   logic        thumb_ff, thumb_in;
   logic [8:0]  exc_ff, exc_in;
   logic        ssel_ff, ssel_in;

   logic        use_main;
   logic        is_gen;
   logic [31:0] reg_rdata;
   logic [31:0] xpsr;
   logic [31:0] sp_wdata;
   logic        cond_pass;

   assign use_main = (exc_ff != 9'd0) || !ssel_ff;
   assign is_gen   = (req.reg_index < 4'(arf_pkg::NUM_GEN_REGS));
   assign sp_wdata = {req.write_value[31:2], 2'b00};
   assign xpsr     = {flags_ff, 3'b000, thumb_ff, 15'd0, exc_ff};

   // Register read mux
   always_comb begin
      if (is_gen) begin
         reg_rdata = gen_ff[req.reg_index];
      end else begin
         case (req.reg_index)
            arf_pkg::REG_SP: reg_rdata = use_main ? msp_ff : psp_ff;
            arf_pkg::REG_LR: reg_rdata = lr_ff;
            default:         reg_rdata = pc_ff;
         endcase
      end
   end

   arf_cond_check u_cond (
      .flags  (flags_ff),
      .code   (req.condition_code),
      .passed (cond_pass)
   );

   // Next state for one request
   always_comb begin
      gen_in   = gen_ff;
      pc_in    = pc_ff;
      lr_in    = lr_ff;
      msp_in   = msp_ff;
      psp_in   = psp_ff;
      flags_in = flags_ff;
      thumb_in = thumb_ff;
      exc_in   = exc_ff;
      ssel_in  = ssel_ff;
      case (req.kind)
         arf_pkg::REQ_WRITE_REG: begin
            if (is_gen) begin
               gen_in[req.reg_index] = req.write_value;
            end else begin
               case (req.reg_index)
                  arf_pkg::REG_SP: begin
                     if (use_main) begin
                        msp_in = sp_wdata;
                     end else begin
                        psp_in = sp_wdata;
                     end
                  end
                  arf_pkg::REG_LR: lr_in = req.write_value;
                  default:         pc_in = req.write_value;
               endcase
            end
         end
         arf_pkg::REQ_WRITE_FLAGS: flags_in = req.flags_in;
         arf_pkg::REQ_SET_NZ: begin
            flags_in = {req.write_value[31], (req.write_value == 32'd0), flags_ff[1:0]};
         end
         arf_pkg::REQ_WRITE_APSR: flags_in = req.write_value[31:28];
         arf_pkg::REQ_WRITE_XPSR: begin
            flags_in = req.write_value[31:28];
            thumb_in = req.write_value[24];
            exc_in   = req.write_value[8:0];
         end
         arf_pkg::REQ_SET_SSEL: ssel_in = req.stack_select_in;
         default: ;
      endcase
   end

   // Result of the request
   always_comb begin
      rsp.read_data        = 32'd0;
      rsp.condition_passed = 1'b0;
      rsp.flags_out        = flags_in;
      case (req.kind)
         arf_pkg::REQ_READ_REG:  rsp.read_data = reg_rdata;
         arf_pkg::REQ_READ_XPSR: rsp.read_data = xpsr;
         arf_pkg::REQ_CONDITION: rsp.condition_passed = cond_pass;
         default: ;
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < arf_pkg::NUM_GEN_REGS; i++) begin
            gen_ff[i] <= 32'd0;
         end
         pc_ff    <= 32'd0;
         lr_ff    <= arf_pkg::LINK_RESET;
         msp_ff   <= 32'd0;
         psp_ff   <= 32'd0;
         flags_ff <= 4'd0;
         thumb_ff <= 1'b1;
         exc_ff   <= 9'd0;
         ssel_ff  <= 1'b0;
      end else if (exec) begin
         gen_ff   <= gen_in;
         pc_ff    <= pc_in;
         lr_ff    <= lr_in;
         msp_ff   <= msp_in;
         psp_ff   <= psp_in;
         flags_ff <= flags_in;
         thumb_ff <= thumb_in;
         exc_ff   <= exc_in;
         ssel_ff  <= ssel_in;
      end
   end

endmodule

### sv/armv6m_register_file_core.sv
// Flow: a request is registered at acceptance and executed from the request register
// once the response register is free; its response is then held in the response register.
// Throughput: one request per cycle while the output is not stalled, set by the
// single execute step between the request register and the response register; state updates in that step.
// Reset: synchronous, active high; clears all core registers to zero, link
// register and its CSR to all ones, thumb bit to one, and empties both stages.
module armv6m_register_file_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // reg_index[3:0], write_value[35:4], flags_in[39:36],
                                   // condition_code[43:40], stack_select_in[44], zero pad
   input  logic [3:0]  req_tuser,  // req_type[3:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // read_data[31:0], condition_passed[32],
                                   // flags_out[36:33], zero pad
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                  in_valid_ff, in_valid_in;
   arf_pkg::req_item_type in_req_ff, in_req_in;
   logic                  out_valid_ff, out_valid_in;
   arf_pkg::rsp_item_type out_rsp_ff, out_rsp_in;
   arf_pkg::rsp_item_type exec_rsp;
   logic                  out_free;
   logic                  advance;
   logic                  req_take;

   // Handshake and stage movement
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   // Request register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_req_in   = in_req_ff;
      if (req_take) begin
         in_valid_in               = 1'b1;
         in_req_in.kind            = arf_pkg::req_kind_type'(req_tuser);
         in_req_in.reg_index       = req_tdata[3:0];
         in_req_in.write_value     = req_tdata[35:4];
         in_req_in.flags_in        = req_tdata[39:36];
         in_req_in.condition_code  = req_tdata[43:40];
         in_req_in.stack_select_in = req_tdata[44];
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   arf_core_regs u_core (
      .clock (clock),
      .reset (reset),
      .exec  (advance),
      .req   (in_req_ff),
      .rsp   (exec_rsp)
   );

   // Response register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_rsp_in   = out_rsp_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_rsp_in   = exec_rsp;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_req_ff  <= in_req_in;
      out_rsp_ff <= out_rsp_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'd0, out_rsp_ff.flags_out, out_rsp_ff.condition_passed,
                        out_rsp_ff.read_data};

   arf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // An executed request always shows up as a response next cycle
   a_exec_to_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("executed request produced no response");

   // A held request blocks new ones while the output is stalled
   a_hold_blocks: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request accepted while request stage is blocked");

   // Reset empties both stages
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!in_valid_ff && !rsp_tvalid))
      else $error("stages not empty after reset");

endmodule

### dv/armv6m_register_file_core_test.sv
// Self-checking testbench for the core register file: directed and random requests.
module armv6m_register_file_core_test;

   localparam logic [2:0]  ADDR_LINK_RESET = 3'd0;
   localparam logic [2:0]  ADDR_UNMAPPED   = 3'd4;
   localparam int          RANDOM_ITEMS    = 1450;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // reg_index[3:0], write_value[35:4], flags_in[39:36],
                             // condition_code[43:40], stack_select_in[44], zero pad
   logic [3:0]  req_tuser;   // req_type[3:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // read_data[31:0], condition_passed[32],
                             // flags_out[36:33], zero pad
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   armv6m_register_file_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow copy of the architectural state
   logic [31:0] gpr_shadow [arf_pkg::NUM_GEN_REGS];
   logic [31:0] pc_shadow;
   logic [31:0] lr_shadow;
   logic [31:0] msp_shadow;
   logic [31:0] psp_shadow;
   logic [3:0]  nzcv_shadow;
   logic        thumb_shadow;
   logic [8:0]  excnum_shadow;
   logic        ssel_shadow;
   logic [31:0] link_reset_csr;

   arf_pkg::rsp_item_type access_results [$];
   arf_pkg::rsp_item_type want_rsp;
   arf_pkg::rsp_item_type got_rsp;

   int failures;
   int burst_left;
   int rsp_checked;
   int csr_writes;
   int kind_count [16];

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit
   initial begin
      #6_000_000;
      $display("armv6m_register_file_core test failed");
      $finish;
   end

   // Apply one request to the shadow state and return the response it should produce
   function automatic arf_pkg::rsp_item_type core_access(
      input logic [3:0] kind, input logic [3:0] idx,
      input logic [31:0] val, input logic [3:0] fin,
      input logic [3:0] cc, input logic ssel);
      arf_pkg::rsp_item_type r;
      logic main_sp;
      logic n, z, c, v, hit;
      r = '0;
      main_sp = (excnum_shadow != 9'd0) || !ssel_shadow;
      {n, z, c, v} = nzcv_shadow;
      case (kind)
         arf_pkg::REQ_READ_REG: begin
            if (idx < arf_pkg::REG_SP)       r.read_data = gpr_shadow[idx];
            else if (idx == arf_pkg::REG_SP) r.read_data = main_sp ? msp_shadow : psp_shadow;
            else if (idx == arf_pkg::REG_LR) r.read_data = lr_shadow;
            else                             r.read_data = pc_shadow;
         end
         arf_pkg::REQ_WRITE_REG: begin
            if (idx < arf_pkg::REG_SP)       gpr_shadow[idx] = val;
            else if (idx == arf_pkg::REG_SP) begin
               if (main_sp) msp_shadow = {val[31:2], 2'b00};
               else         psp_shadow = {val[31:2], 2'b00};
            end
            else if (idx == arf_pkg::REG_LR) lr_shadow = val;
            else                             pc_shadow = val;
         end
         arf_pkg::REQ_WRITE_FLAGS: nzcv_shadow = fin;
         arf_pkg::REQ_SET_NZ:      nzcv_shadow = {val[31], val == 32'd0, c, v};
         arf_pkg::REQ_READ_XPSR: begin
            r.read_data = {nzcv_shadow, 3'b000, thumb_shadow, 15'd0, excnum_shadow};
         end
         arf_pkg::REQ_WRITE_APSR:  nzcv_shadow = val[31:28];
         arf_pkg::REQ_WRITE_XPSR: begin
            nzcv_shadow   = val[31:28];
            thumb_shadow  = val[24];
            excnum_shadow = val[8:0];
         end
         arf_pkg::REQ_CONDITION: begin
            case (arf_pkg::cond_group_type'(cc[3:1]))
               arf_pkg::COND_EQ: hit = z;
               arf_pkg::COND_CS: hit = c;
               arf_pkg::COND_MI: hit = n;
               arf_pkg::COND_VS: hit = v;
               arf_pkg::COND_HI: hit = c && !z;
               arf_pkg::COND_GE: hit = (n == v);
               arf_pkg::COND_GT: hit = (n == v) && !z;
               default:          hit = 1'b1;
            endcase
            // odd codes invert, except the second always-code
            if (cc[0] && cc != arf_pkg::COND_ALWAYS_ALT) hit = !hit;
            r.condition_passed = hit;
         end
         arf_pkg::REQ_SET_SSEL: ssel_shadow = ssel;
         default: ;
      endcase
      r.flags_out = nzcv_shadow;
      return r;
   endfunction

   // Send one request transaction; the sender runs in bursts with random gaps
   task automatic issue_request(input logic [3:0] kind, input logic [3:0] idx,
                                input logic [31:0] val, input logic [3:0] fin,
                                input logic [3:0] cc, input logic ssel);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = {3'b000, ssel, cc, fin, val, idx};
      do @(posedge clock); while (!req_tready);
      access_results.push_back(core_access(kind, idx, val, fin, cc, ssel));
      kind_count[kind]++;
   endtask

   // Stop sending and let every outstanding response arrive
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left = 0;
      while (access_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = addr;
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_LINK_RESET) link_reset_csr = data;
      csr_writes++;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic csr_read_check(input logic [2:0] addr);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b0;
      csr_penable = 1'b0;
      csr_paddr   = addr;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== link_reset_csr) begin
         $error("field link_reset_value: expected %h, actual %h", link_reset_csr, csr_prdata);
         failures++;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // Response checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rsp.read_data        = rsp_tdata[31:0];
         got_rsp.condition_passed = rsp_tdata[32];
         got_rsp.flags_out        = rsp_tdata[36:33];
         if (access_results.size() == 0) begin
            $error("response transaction with none outstanding: %h", rsp_tdata);
            failures++;
         end else begin
            want_rsp = access_results.pop_front();
            rsp_checked++;
            if (got_rsp.read_data !== want_rsp.read_data) begin
               $error("field read_data: expected %h, actual %h",
                      want_rsp.read_data, got_rsp.read_data);
               failures++;
            end
            if (got_rsp.condition_passed !== want_rsp.condition_passed) begin
               $error("field condition_passed: expected %b, actual %b",
                      want_rsp.condition_passed, got_rsp.condition_passed);
               failures++;
            end
            if (got_rsp.flags_out !== want_rsp.flags_out) begin
               $error("field flags_out: expected %h, actual %h",
                      want_rsp.flags_out, got_rsp.flags_out);
               failures++;
            end
         end
      end
   end

   // Receiver back-pressure: a rotating stall mask, reloaded per epoch
   initial begin
      logic [31:0] stall_mask;
      int          epoch_left;
      logic        free_run;
      stall_mask = '1;
      epoch_left = 0;
      free_run   = 1'b1;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (epoch_left == 0) begin
            epoch_left = $urandom_range(16, 96);
            stall_mask = $urandom;
            free_run   = ($urandom_range(0, 3) == 0);
         end
         epoch_left--;
         rsp_tready = free_run || stall_mask[0] || (stall_mask == '0);
         stall_mask = {stall_mask[0], stall_mask[31:1]};
      end
   end

   // Link reset CSR: reset value, extremes, and an unmapped address
   task automatic test_csr_access();
      csr_read_check(ADDR_LINK_RESET);
      csr_write(ADDR_LINK_RESET, 32'h0000_0000);
      csr_read_check(ADDR_LINK_RESET);
      csr_write(ADDR_UNMAPPED, 32'hDEAD_BEEF);
      csr_read_check(ADDR_LINK_RESET);
      csr_write(ADDR_LINK_RESET, 32'hFFFF_FFFF);
      csr_read_check(ADDR_LINK_RESET);
   endtask

   // Link register after reset, general register and PC at full width
   task automatic test_register_access();
      issue_request(arf_pkg::REQ_READ_REG, arf_pkg::REG_LR, 32'd0, 4'h0, 4'h0, 1'b0);
      issue_request(arf_pkg::REQ_WRITE_REG, 4'd0, 32'hFFFF_FFFF, 4'h0, 4'h0, 1'b0);
      issue_request(arf_pkg::REQ_READ_REG, 4'd0, 32'd0, 4'h0, 4'h0, 1'b0);
      issue_request(arf_pkg::REQ_WRITE_REG, arf_pkg::REG_PC, 32'hFFFF_FFFF, 4'hF, 4'hF, 1'b1);
      issue_request(arf_pkg::REQ_READ_REG, arf_pkg::REG_PC, 32'd0, 4'h0, 4'h0, 1'b0);
   endtask

   // Banked stack pointer: thread mode with either select, handler mode forcing main
   task automatic test_stack_banking();
      issue_request(arf_pkg::REQ_WRITE_REG, arf_pkg::REG_SP, 32'hFFFF_FFFF, 4'h0, 4'h0, 1'b0);
      issue_request(arf_pkg::REQ_SET_SSEL, 4'd0, 32'd0, 4'h0, 4'h0, 1'b1);
      issue_request(arf_pkg::REQ_READ_REG, arf_pkg::REG_SP, 32'd0, 4'h0, 4'h0, 1'b0);
      issue_request(arf_pkg::REQ_WRITE_REG, arf_pkg::REG_SP, 32'h0000_0007, 4'h0, 4'h0, 1'b0);
      issue_request(arf_pkg::REQ_WRITE_XPSR, 4'd0, 32'h0100_01FF, 4'h0, 4'h0, 1'b0);
      issue_request(arf_pkg::REQ_READ_REG, arf_pkg::REG_SP, 32'd0, 4'h0, 4'h0, 1'b0);
      issue_request(arf_pkg::REQ_WRITE_XPSR, 4'd0, 32'h0000_0000, 4'h0, 4'h0, 1'b0);
      issue_request(arf_pkg::REQ_READ_REG, arf_pkg::REG_SP, 32'd0, 4'h0, 4'h0, 1'b0);
      issue_request(arf_pkg::REQ_SET_SSEL, 4'd0, 32'd0, 4'h0, 4'h0, 1'b0);
   endtask

   // Flag writes, NZ from a value, APSR, composed xPSR
   task automatic test_psr_access();
      issue_request(arf_pkg::REQ_WRITE_FLAGS, 4'd0, 32'd0, 4'hF, 4'h0, 1'b0);
      issue_request(arf_pkg::REQ_READ_XPSR, 4'd0, 32'd0, 4'h0, 4'h0, 1'b0);
      issue_request(arf_pkg::REQ_SET_NZ, 4'd0, 32'h0000_0000, 4'h0, 4'h0, 1'b0);
      issue_request(arf_pkg::REQ_SET_NZ, 4'd0, 32'h8000_0000, 4'h0, 4'h0, 1'b0);
      issue_request(arf_pkg::REQ_WRITE_APSR, 4'd0, 32'hA000_0000, 4'h0, 4'h0, 1'b0);
      issue_request(arf_pkg::REQ_READ_XPSR, 4'd0, 32'd0, 4'h0, 4'h0, 1'b0);
   endtask

   // Condition codes: plain, inverted, compound and both always-codes
   task automatic test_condition_codes();
      issue_request(arf_pkg::REQ_WRITE_FLAGS, 4'd0, 32'd0, 4'b0101, 4'h0, 1'b0);
      issue_request(arf_pkg::REQ_CONDITION, 4'd0, 32'd0, 4'h0, 4'h0, 1'b0);
      issue_request(arf_pkg::REQ_CONDITION, 4'd0, 32'd0, 4'h0, 4'h1, 1'b0);
      issue_request(arf_pkg::REQ_CONDITION, 4'd0, 32'd0, 4'h0, 4'h8, 1'b0);
      issue_request(arf_pkg::REQ_CONDITION, 4'd0, 32'd0, 4'h0, 4'hB, 1'b0);
      issue_request(arf_pkg::REQ_CONDITION, 4'd0, 32'd0, 4'h0, 4'hE, 1'b0);
      issue_request(arf_pkg::REQ_CONDITION, 4'd0, 32'd0, 4'h0,
                    arf_pkg::COND_ALWAYS_ALT, 1'b0);
   endtask

   // Undefined request kinds leave state alone
   task automatic test_unknown_requests();
      issue_request(4'd9, 4'd0, 32'hFFFF_FFFF, 4'h0, 4'hF, 1'b1);
      issue_request(4'd15, arf_pkg::REG_SP, 32'h1234_5678, 4'hF, 4'h0, 1'b1);
   endtask

   // Random traffic with periodic CSR updates while idle
   task automatic test_random_traffic();
      int          n;
      int          pick;
      logic [3:0]  kind;
      logic [3:0]  idx;
      logic [31:0] val;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         // pause until all responses are back, then reprogram the CSR
         if (n > 0 && n % 360 == 0) begin
            wait_idle();
            case ((n / 360) % 4)
               0:       csr_write(ADDR_LINK_RESET, 32'h0000_0000);
               1:       csr_write(ADDR_LINK_RESET, $urandom);
               2:       csr_write(ADDR_LINK_RESET, 32'h8000_0000);
               default: csr_write(ADDR_LINK_RESET, 32'hFFFF_FFFF);
            endcase
            csr_read_check(ADDR_LINK_RESET);
         end
         pick = $urandom_range(0, 99);
         if (pick < 22)      kind = arf_pkg::REQ_READ_REG;
         else if (pick < 44) kind = arf_pkg::REQ_WRITE_REG;
         else if (pick < 50) kind = arf_pkg::REQ_WRITE_FLAGS;
         else if (pick < 56) kind = arf_pkg::REQ_SET_NZ;
         else if (pick < 62) kind = arf_pkg::REQ_READ_XPSR;
         else if (pick < 66) kind = arf_pkg::REQ_WRITE_APSR;
         else if (pick < 70) kind = arf_pkg::REQ_WRITE_XPSR;
         else if (pick < 88) kind = arf_pkg::REQ_CONDITION;
         else if (pick < 94) kind = arf_pkg::REQ_SET_SSEL;
         else                kind = 4'($urandom_range(9, 15));
         val = $urandom;
         case ($urandom_range(0, 9))
            0: val = 32'h0000_0000;
            1: val = 32'hFFFF_FFFF;
            2: val = 32'h8000_0000;
            default: ;
         endcase
         // keep thread mode reachable most of the time
         if (kind == arf_pkg::REQ_WRITE_XPSR && $urandom_range(0, 2) != 0) val[8:0] = 9'd0;
         idx = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(13, 15))
                                           : 4'($urandom_range(0, 15));
         issue_request(kind, idx, val, 4'($urandom_range(0, 15)),
                       4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      end
   endtask

   // Main sequence
   initial begin
      int i;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      reset       = 1'b1;
      failures    = 0;
      burst_left  = 0;
      rsp_checked = 0;
      csr_writes  = 0;
      for (i = 0; i < 16; i++) kind_count[i] = 0;
      for (i = 0; i < arf_pkg::NUM_GEN_REGS; i++) gpr_shadow[i] = '0;
      pc_shadow      = '0;
      lr_shadow      = arf_pkg::LINK_RESET;
      msp_shadow     = '0;
      psp_shadow     = '0;
      nzcv_shadow    = '0;
      thumb_shadow   = 1'b1;
      excnum_shadow  = '0;
      ssel_shadow    = 1'b0;
      link_reset_csr = arf_pkg::LINK_RESET;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_csr_access();
      test_register_access();
      test_stack_banking();
      test_psr_access();
      test_condition_codes();
      test_unknown_requests();
      wait_idle();
      test_random_traffic();
      wait_idle();

      if (access_results.size() != 0) begin
         $error("%0d response transactions never arrived", access_results.size());
         failures++;
      end
      $display("Covered %0d register reads, %0d register writes, %0d condition checks,",
               kind_count[arf_pkg::REQ_READ_REG], kind_count[arf_pkg::REQ_WRITE_REG],
               kind_count[arf_pkg::REQ_CONDITION]);
      $display("PSR/flag/stack-select updates and %0d CSR writes; %0d responses checked.",
               csr_writes, rsp_checked);
      if (failures == 0) begin
         $display("armv6m_register_file_core test passed");
      end else begin
         $display("armv6m_register_file_core test failed");
      end
      $finish;
   end

endmodule

### filelist.f
sv/arf_pkg.sv
sv/arf_csr.sv
sv/arf_cond_check.sv
sv/arf_core_regs.sv
sv/armv6m_register_file_core.sv
dv/armv6m_register_file_core_test.sv
